// ===== hw/rtl/rrte_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the relative rotation to Euler pipeline.
// No dependencies; used by every RTL file of the block.
package rrte_pkg;

	localparam int ANGLE_ITERATIONS = 16;
	localparam int ATAN_TABLE_LEN   = 24;
	localparam int ITERS = (ANGLE_ITERATIONS < ATAN_TABLE_LEN) ? ANGLE_ITERATIONS : ATAN_TABLE_LEN;

	localparam int COMP_W      = 16;
	localparam int IN_TDATA_W  = 8 * COMP_W;
	localparam int OUT_TDATA_W = 48;
	localparam int VW          = 52;   // width of atan2 operands
	localparam int NORM_BITS   = 40;   // normalized magnitude lies in [2^39, 2^40)
	localparam int CW          = 44;   // CORDIC x/y width
	localparam int ZW          = 28;   // angle width, 2^-24 rad units
	localparam int SQRT_STAGES = 30;   // one root bit per stage
	localparam int SQRT_IN_W   = 2 * SQRT_STAGES;
	localparam int ATAN_LAT    = ITERS + 4;

	localparam logic signed [ZW-1:0] PI_U24      = 28'sd52707179;
	localparam logic signed [ZW-1:0] HALF_PI_U24 = 28'sd26353589;
	localparam logic signed [ZW-1:0] ANGLE_MAX   = 28'sd25736;
	localparam logic signed [ZW-1:0] PITCH_MAX   = 28'sd12868;

	// Roll and yaw atan2 operands travel together
	typedef struct packed {
		logic signed [VW-1:0] ry;
		logic signed [VW-1:0] rx;
		logic signed [VW-1:0] yy;
		logic signed [VW-1:0] yx;
	} ang_t;

	// Pitch side information
	typedef struct packed {
		logic        zn;
		logic        clamp;
		logic        sneg;
		logic [29:0] us;
	} pmeta_t;

	function automatic logic [VW-1:0] mag52(input logic signed [VW-1:0] v);
		logic signed [VW-1:0] a;
		a = v[VW-1] ? -v : v;
		return a;
	endfunction

	function automatic logic [5:0] bitlen52(input logic [VW-1:0] v);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < VW; i++) begin
			if (v[i]) n = 6'(i + 1);
		end
		return n;
	endfunction

	// atan(2^-i) in 2^-24 rad, rounded to nearest
	function automatic logic [25:0] atan_tab(input logic [4:0] i);
		logic [25:0] r;
		case (i)
			5'd0:    r = 26'd13176795;
			5'd1:    r = 26'd7778716;
			5'd2:    r = 26'd4110060;
			5'd3:    r = 26'd2086331;
			5'd4:    r = 26'd1047214;
			5'd5:    r = 26'd524117;
			5'd6:    r = 26'd262123;
			5'd7:    r = 26'd131069;
			5'd8:    r = 26'd65536;
			5'd9:    r = 26'd32768;
			5'd10:   r = 26'd16384;
			5'd11:   r = 26'd8192;
			5'd12:   r = 26'd4096;
			5'd13:   r = 26'd2048;
			5'd14:   r = 26'd1024;
			5'd15:   r = 26'd512;
			5'd16:   r = 26'd256;
			5'd17:   r = 26'd128;
			5'd18:   r = 26'd64;
			5'd19:   r = 26'd32;
			5'd20:   r = 26'd16;
			5'd21:   r = 26'd8;
			5'd22:   r = 26'd4;
			5'd23:   r = 26'd2;
			default: r = 26'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/rrte_atan2.sv =====
`timescale 1ns / 1ps
// Pipelined atan2: magnitude normalization, one CORDIC vectoring stage per iteration,
// quadrant mirror. Depends on rrte_pkg.
module rrte_atan2 (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [rrte_pkg::VW-1:0] y,
	input  logic signed [rrte_pkg::VW-1:0] x,
	output logic signed [rrte_pkg::ZW-1:0] ang
);

	logic [rrte_pkg::VW-1:0] ax_s1, ay_s1;
	logic                    xneg_s1, yneg_s1;
	logic [rrte_pkg::VW-1:0] ax_s2, ay_s2;
	logic [5:0]              bl_s2;
	logic                    xneg_s2, yneg_s2, zero_s2;

	logic signed [rrte_pkg::CW-1:0] cx_sn [rrte_pkg::ITERS+1];
	logic signed [rrte_pkg::CW-1:0] cy_sn [rrte_pkg::ITERS+1];
	logic signed [rrte_pkg::ZW-1:0] z_sn  [rrte_pkg::ITERS+1];
	logic [2:0]                     fl_sn [rrte_pkg::ITERS+1];  // {zero, yneg, xneg}

	logic [rrte_pkg::VW-1:0] axn, ayn;
	logic signed [rrte_pkg::ZW-1:0] a_mir;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= rrte_pkg::mag52(x);
			ay_s1   <= rrte_pkg::mag52(y);
			xneg_s1 <= x[rrte_pkg::VW-1];
			yneg_s1 <= y[rrte_pkg::VW-1];
		end
	end

	// bit length of the larger magnitude equals that of the OR of both
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			bl_s2   <= rrte_pkg::bitlen52(ax_s1 | ay_s1);
			zero_s2 <= ((ax_s1 | ay_s1) == '0);
			xneg_s2 <= xneg_s1;
			yneg_s2 <= yneg_s1;
		end
	end

	always_comb begin
		if (bl_s2 > 6'(rrte_pkg::NORM_BITS)) begin
			axn = ax_s2 >> (bl_s2 - 6'(rrte_pkg::NORM_BITS));
			ayn = ay_s2 >> (bl_s2 - 6'(rrte_pkg::NORM_BITS));
		end else begin
			axn = ax_s2 << (6'(rrte_pkg::NORM_BITS) - bl_s2);
			ayn = ay_s2 << (6'(rrte_pkg::NORM_BITS) - bl_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_sn[0] <= $signed({{(rrte_pkg::CW-rrte_pkg::NORM_BITS){1'b0}},
				axn[rrte_pkg::NORM_BITS-1:0]});
			cy_sn[0] <= $signed({{(rrte_pkg::CW-rrte_pkg::NORM_BITS){1'b0}},
				ayn[rrte_pkg::NORM_BITS-1:0]});
			z_sn[0]  <= '0;
			fl_sn[0] <= {zero_s2, yneg_s2, xneg_s2};
		end
	end

	for (genvar i = 0; i < rrte_pkg::ITERS; i++) begin : g_cordic
		localparam logic signed [rrte_pkg::ZW-1:0] STEP =
			$signed({2'b00, rrte_pkg::atan_tab(5'(i))});
		logic signed [rrte_pkg::CW-1:0] dx, dy;
		assign dx = cy_sn[i] >>> i;
		assign dy = cx_sn[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				// rotate toward the x axis
				if (!cy_sn[i][rrte_pkg::CW-1]) begin
					cx_sn[i+1] <= cx_sn[i] + dx;
					cy_sn[i+1] <= cy_sn[i] - dy;
					z_sn[i+1]  <= z_sn[i] + STEP;
				end else begin
					cx_sn[i+1] <= cx_sn[i] - dx;
					cy_sn[i+1] <= cy_sn[i] + dy;
					z_sn[i+1]  <= z_sn[i] - STEP;
				end
				fl_sn[i+1] <= fl_sn[i];
			end
		end
	end

	assign a_mir = fl_sn[rrte_pkg::ITERS][0] ? (rrte_pkg::PI_U24 - z_sn[rrte_pkg::ITERS])
		: z_sn[rrte_pkg::ITERS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (fl_sn[rrte_pkg::ITERS][2]) ang <= '0;
			else if (fl_sn[rrte_pkg::ITERS][1]) ang <= -a_mir;
			else ang <= a_mir;
		end
	end

endmodule

// ===== hw/rtl/relative_rotation_to_euler.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle; set by the 30 one-bit square-root stages and the
// per-iteration CORDIC stages, all fully pipelined with one shared stall enable.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// Top level: quaternion difference, scaling, squared terms, pitch root, three atan2 units.
// Depends on rrte_pkg and rrte_atan2.
module relative_rotation_to_euler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// from bit 0: truth_qw, truth_qx, truth_qy, truth_qz, est_qw, est_qx, est_qy, est_qz
	input  logic [rrte_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// from bit 0: roll_err[15:0], pitch_err[14:0], yaw_err[15:0], one zero pad bit
	output logic [rrte_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// bit 0: zero_norm
	output logic                                m_tuser
);

	// The whole pipe moves when the output register is empty or being taken.
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ---------------- stage 1: all 16x16 products ----------------
	logic signed [15:0] tq [4];
	logic signed [15:0] eq [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tq[i] = $signed(s_tdata[16*i +: 16]);
			eq[i] = $signed(s_tdata[64 + 16*i +: 16]);
		end
	end

	logic               vld_s1, zn_s1;
	logic signed [31:0] pr_s1 [20];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zn_s1     <= (tq[0] == 16'sd0) && (tq[1] == 16'sd0) && (tq[2] == 16'sd0)
				&& (tq[3] == 16'sd0);
			// norm
			pr_s1[0]  <= tq[0] * tq[0];
			pr_s1[1]  <= tq[1] * tq[1];
			pr_s1[2]  <= tq[2] * tq[2];
			pr_s1[3]  <= tq[3] * tq[3];
			// w of conj(t)*e
			pr_s1[4]  <= tq[0] * eq[0];
			pr_s1[5]  <= tq[1] * eq[1];
			pr_s1[6]  <= tq[2] * eq[2];
			pr_s1[7]  <= tq[3] * eq[3];
			// x
			pr_s1[8]  <= tq[0] * eq[1];
			pr_s1[9]  <= tq[1] * eq[0];
			pr_s1[10] <= tq[2] * eq[3];
			pr_s1[11] <= tq[3] * eq[2];
			// y
			pr_s1[12] <= tq[0] * eq[2];
			pr_s1[13] <= tq[2] * eq[0];
			pr_s1[14] <= tq[3] * eq[1];
			pr_s1[15] <= tq[1] * eq[3];
			// z
			pr_s1[16] <= tq[0] * eq[3];
			pr_s1[17] <= tq[3] * eq[0];
			pr_s1[18] <= tq[1] * eq[2];
			pr_s1[19] <= tq[2] * eq[1];
		end
	end

	// ---------------- stage 2: sum into p and n ----------------
	logic               vld_s2, zn_s2;
	logic signed [33:0] pw_s2, px_s2, py_s2, pz_s2;
	logic signed [33:0] nsum;
	logic [32:0]        nn_s2;
	assign nsum = 34'(pr_s1[0]) + 34'(pr_s1[1]) + 34'(pr_s1[2]) + 34'(pr_s1[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zn_s2 <= zn_s1;
			nn_s2 <= nsum[32:0];
			pw_s2 <= 34'(pr_s1[4]) + 34'(pr_s1[5]) + 34'(pr_s1[6]) + 34'(pr_s1[7]);
			px_s2 <= 34'(pr_s1[8]) - 34'(pr_s1[9]) - 34'(pr_s1[10]) + 34'(pr_s1[11]);
			py_s2 <= 34'(pr_s1[12]) - 34'(pr_s1[13]) - 34'(pr_s1[14]) + 34'(pr_s1[15]);
			pz_s2 <= 34'(pr_s1[16]) - 34'(pr_s1[17]) - 34'(pr_s1[18]) + 34'(pr_s1[19]);
		end
	end

	// ---------------- stage 3: largest magnitude ----------------
	logic [32:0] mw, mx, my, mz, mmax;
	logic [rrte_pkg::VW-1:0] mtmp_w, mtmp_x, mtmp_y, mtmp_z;
	assign mtmp_w = rrte_pkg::mag52(52'(pw_s2));
	assign mtmp_x = rrte_pkg::mag52(52'(px_s2));
	assign mtmp_y = rrte_pkg::mag52(52'(py_s2));
	assign mtmp_z = rrte_pkg::mag52(52'(pz_s2));
	assign mw = mtmp_w[32:0];
	assign mx = mtmp_x[32:0];
	assign my = mtmp_y[32:0];
	assign mz = mtmp_z[32:0];
	always_comb begin
		mmax = nn_s2;
		if (mw > mmax) mmax = mw;
		if (mx > mmax) mmax = mx;
		if (my > mmax) mmax = my;
		if (mz > mmax) mmax = mz;
	end

	logic               vld_s3, zn_s3;
	logic signed [33:0] pw_s3, px_s3, py_s3, pz_s3;
	logic [32:0]        nn_s3, m_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zn_s3 <= zn_s2;
			pw_s3 <= pw_s2;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			pz_s3 <= pz_s2;
			nn_s3 <= nn_s2;
			m_s3  <= mmax;
		end
	end

	// ---------------- stage 4: common scaling to 24 bits ----------------
	logic [5:0] mbl;
	logic [3:0] ksh;
	assign mbl = rrte_pkg::bitlen52(52'(m_s3));
	assign ksh = (mbl > 6'd24) ? 4'(mbl - 6'd24) : 4'd0;

	logic               vld_s4, zn_s4;
	logic signed [24:0] pw_s4, px_s4, py_s4, pz_s4;
	logic [23:0]        nn_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zn_s4 <= zn_s3;
			pw_s4 <= 25'(pw_s3 >>> ksh);
			px_s4 <= 25'(px_s3 >>> ksh);
			py_s4 <= 25'(py_s3 >>> ksh);
			pz_s4 <= 25'(pz_s3 >>> ksh);
			nn_s4 <= 24'(nn_s3 >> ksh);
		end
	end

	// ---------------- stage 5: second-order products ----------------
	logic               vld_s5, zn_s5;
	logic signed [49:0] wx_s5, yz_s5, xx_s5, yy_s5, wz_s5, xy_s5, zz_s5, wy_s5, zx_s5;
	logic [47:0]        n2_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= vld_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zn_s5 <= zn_s4;
			wx_s5 <= pw_s4 * px_s4;
			yz_s5 <= py_s4 * pz_s4;
			xx_s5 <= px_s4 * px_s4;
			yy_s5 <= py_s4 * py_s4;
			wz_s5 <= pw_s4 * pz_s4;
			xy_s5 <= px_s4 * py_s4;
			zz_s5 <= pz_s4 * pz_s4;
			wy_s5 <= pw_s4 * py_s4;
			zx_s5 <= pz_s4 * px_s4;
			n2_s5 <= nn_s4 * nn_s4;
		end
	end

	// ---------------- stage 6: atan2 operands ----------------
	logic signed [rrte_pkg::VW-1:0] n2sg;
	assign n2sg = $signed({4'b0000, n2_s5});

	logic                           vld_s6, zn_s6;
	rrte_pkg::ang_t                 ang_s6;
	logic signed [rrte_pkg::VW-1:0] s_s6;
	logic [47:0]                    n2_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (adv) vld_s6 <= vld_s5;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zn_s6     <= zn_s5;
			n2_s6     <= n2_s5;
			ang_s6.ry <= (52'(wx_s5) + 52'(yz_s5)) <<< 1;
			ang_s6.rx <= n2sg - ((52'(xx_s5) + 52'(yy_s5)) <<< 1);
			ang_s6.yy <= (52'(wz_s5) + 52'(xy_s5)) <<< 1;
			ang_s6.yx <= n2sg - ((52'(yy_s5) + 52'(zz_s5)) <<< 1);
			s_s6      <= (52'(wy_s5) - 52'(zx_s5)) <<< 1;
		end
	end

	// ---------------- stage 7: pitch magnitude and root scaling ----------------
	logic [5:0] n2bl;
	assign n2bl = rrte_pkg::bitlen52(52'(n2_s6));

	logic                    vld_s7, zn_s7, sneg_s7;
	rrte_pkg::ang_t          ang_s7;
	logic [rrte_pkg::VW-1:0] us_s7;
	logic [47:0]             n2_s7;
	logic [4:0]              k2_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (adv) vld_s7 <= vld_s6;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zn_s7   <= zn_s6;
			ang_s7  <= ang_s6;
			n2_s7   <= n2_s6;
			us_s7   <= rrte_pkg::mag52(s_s6);
			sneg_s7 <= s_s6[rrte_pkg::VW-1];
			k2_s7   <= (n2bl > 6'd30) ? 5'(n2bl - 6'd30) : 5'd0;
		end
	end

	// ---------------- stage 8: clamp test, shift to 30 bits ----------------
	logic [rrte_pkg::VW-1:0] us_shf;
	logic [47:0]             un_shf;
	assign us_shf = us_s7 >> k2_s7;
	assign un_shf = n2_s7 >> k2_s7;

	logic            vld_s8;
	rrte_pkg::ang_t  ang_s8;
	rrte_pkg::pmeta_t pm_s8;
	logic [29:0]     un_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else if (adv) vld_s8 <= vld_s7;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s8      <= ang_s7;
			pm_s8.zn    <= zn_s7;
			pm_s8.sneg  <= sneg_s7;
			pm_s8.clamp <= (us_s7 >= {4'b0000, n2_s7});
			pm_s8.us    <= us_shf[29:0];
			un_s8       <= un_shf[29:0];
		end
	end

	// ---------------- stage 9: squares for the cosine term ----------------
	logic             vld_s9;
	rrte_pkg::ang_t   ang_s9;
	rrte_pkg::pmeta_t pm_s9;
	logic [59:0]      ussq_s9, unsq_s9;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s9 <= 1'b0;
		else if (adv) vld_s9 <= vld_s8;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s9  <= ang_s8;
			pm_s9   <= pm_s8;
			ussq_s9 <= pm_s8.us * pm_s8.us;
			unsq_s9 <= un_s8 * un_s8;
		end
	end

	// ---------------- stage 10: radicand, feeds the root pipe ----------------
	logic                           vld_sn  [rrte_pkg::SQRT_STAGES+1];
	logic [rrte_pkg::SQRT_IN_W-1:0] v_sn    [rrte_pkg::SQRT_STAGES+1];
	logic [31:0]                    rem_sn  [rrte_pkg::SQRT_STAGES+1];
	logic [29:0]                    root_sn [rrte_pkg::SQRT_STAGES+1];
	rrte_pkg::pmeta_t               pm_sn   [rrte_pkg::SQRT_STAGES+1];
	rrte_pkg::ang_t                 ang_sn  [rrte_pkg::SQRT_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sn[0] <= 1'b0;
		else if (adv) vld_sn[0] <= vld_s9;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			// a clamped pitch never uses the root: feed zero
			v_sn[0]    <= pm_s9.clamp ? '0 : (unsq_s9 - ussq_s9);
			rem_sn[0]  <= '0;
			root_sn[0] <= '0;
			pm_sn[0]   <= pm_s9;
			ang_sn[0]  <= ang_s9;
		end
	end

	// Digit-by-digit integer square root, one result bit per stage, top pair first.
	for (genvar j = 0; j < rrte_pkg::SQRT_STAGES; j++) begin : g_sqrt
		logic [31:0] rem_sh, trial;
		assign rem_sh = {rem_sn[j][29:0], v_sn[j][rrte_pkg::SQRT_IN_W-1 -: 2]};
		assign trial  = {root_sn[j], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sn[j+1] <= 1'b0;
			else if (adv) vld_sn[j+1] <= vld_sn[j];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				v_sn[j+1]   <= v_sn[j] << 2;
				pm_sn[j+1]  <= pm_sn[j];
				ang_sn[j+1] <= ang_sn[j];
				if (rem_sh >= trial) begin
					rem_sn[j+1]  <= rem_sh - trial;
					root_sn[j+1] <= {root_sn[j][28:0], 1'b1};
				end else begin
					rem_sn[j+1]  <= rem_sh;
					root_sn[j+1] <= {root_sn[j][28:0], 1'b0};
				end
			end
		end
	end

	// ---------------- atan2 units ----------------
	localparam int SQ = rrte_pkg::SQRT_STAGES;
	logic signed [rrte_pkg::VW-1:0] pus, py_in, px_in;
	assign pus   = $signed({22'd0, pm_sn[SQ].us});
	assign py_in = pm_sn[SQ].sneg ? -pus : pus;
	assign px_in = $signed({22'd0, root_sn[SQ]});

	logic signed [rrte_pkg::ZW-1:0] roll_a, yaw_a, pitch_a;

	rrte_atan2 u_roll (
		.clk (clk),
		.en  (adv),
		.y   (ang_sn[SQ].ry),
		.x   (ang_sn[SQ].rx),
		.ang (roll_a)
	);

	rrte_atan2 u_yaw (
		.clk (clk),
		.en  (adv),
		.y   (ang_sn[SQ].yy),
		.x   (ang_sn[SQ].yx),
		.ang (yaw_a)
	);

	rrte_atan2 u_pitch (
		.clk (clk),
		.en  (adv),
		.y   (py_in),
		.x   (px_in),
		.ang (pitch_a)
	);

	// Delay valid and pitch flags alongside the atan2 units.
	logic       dl_vld_sn [rrte_pkg::ATAN_LAT];
	logic [2:0] dl_fl_sn  [rrte_pkg::ATAN_LAT];   // {zn, clamp, sneg}
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rrte_pkg::ATAN_LAT; i++) dl_vld_sn[i] <= 1'b0;
		end else if (adv) begin
			dl_vld_sn[0] <= vld_sn[SQ];
			for (int i = 1; i < rrte_pkg::ATAN_LAT; i++) dl_vld_sn[i] <= dl_vld_sn[i-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dl_fl_sn[0] <= {pm_sn[SQ].zn, pm_sn[SQ].clamp, pm_sn[SQ].sneg};
			for (int i = 1; i < rrte_pkg::ATAN_LAT; i++) dl_fl_sn[i] <= dl_fl_sn[i-1];
		end
	end

	// ---------------- output register: round to Q3.13 and clamp ----------------
	function automatic logic [15:0] to_q13(input logic signed [rrte_pkg::ZW-1:0] a,
		input logic signed [rrte_pkg::ZW-1:0] lim);
		logic signed [rrte_pkg::ZW-1:0] r;
		r = (a + 28'sd1024) >>> 11;
		if (r > lim) r = lim;
		else if (r < -lim) r = -lim;
		return r[15:0];
	endfunction

	localparam int DL = rrte_pkg::ATAN_LAT - 1;
	logic signed [rrte_pkg::ZW-1:0] pitch_sel;
	logic [15:0] roll_q, yaw_q, pitch_q;
	always_comb begin
		// boundary case: |S| >= n^2 pins pitch at +-pi/2
		if (dl_fl_sn[DL][1]) pitch_sel = dl_fl_sn[DL][0] ? -rrte_pkg::HALF_PI_U24
			: rrte_pkg::HALF_PI_U24;
		else pitch_sel = pitch_a;
		roll_q  = to_q13(roll_a, rrte_pkg::ANGLE_MAX);
		yaw_q   = to_q13(yaw_a, rrte_pkg::ANGLE_MAX);
		pitch_q = to_q13(pitch_sel, rrte_pkg::PITCH_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (adv) m_tvalid <= dl_vld_sn[DL];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			m_tuser <= dl_fl_sn[DL][2];
			// zero-norm reference: force all angles to zero
			if (dl_fl_sn[DL][2]) m_tdata <= '0;
			else m_tdata <= {1'b0, yaw_q, pitch_q[14:0], roll_q};
		end
	end

endmodule

// ===== hw/rtl/rrte_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for relative_rotation_to_euler, bound to the top level.
// Depends on rrte_pkg.
module rrte_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [rrte_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tuser
);

	// hold a stalled output beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output space");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("zero-norm beat carries nonzero angles");

	a_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd12868)
			&& ($signed(m_tdata[30:16]) >= -15'sd12868))
		else $error("pitch outside +-pi/2");

	a_roll: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd25736)
			&& ($signed(m_tdata[15:0]) >= -16'sd25736) && (m_tdata[47] == 1'b0))
		else $error("roll outside +-pi or pad bit set");

endmodule

bind relative_rotation_to_euler rrte_checker u_rrte_checker (.*);
